// ===== hw/rtl/cts_pkg.sv =====
// Shared types and constants for the cooperative task scheduler.
// No dependencies; every other scheduler file refers to this package.
package cts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = 4;
    localparam int WORD_W    = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_YIELD  = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_START  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        RES_SWITCH   = 2'd0,
        RES_CONTINUE = 2'd1,
        RES_NONE     = 2'd2,
        RES_ERROR    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_INVALID  = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_FINISHED = 2'd3
    } t_slot_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_ctl_cmd;

endpackage

// ===== hw/rtl/cts_ifs.sv =====
// Valid/ready channel interfaces for scheduler events and results.
// Depends on cts_pkg for field widths.
interface cts_req_if;
    logic                              valid;
    logic                              ready;
    logic [cts_pkg::MODE_W-1:0]        mode;
    logic [cts_pkg::WORD_W-1:0]        stack_pointer;
    logic [cts_pkg::WORD_W-1:0]        program_counter;

    modport source (output valid, mode, stack_pointer, program_counter, input ready);
    modport sink   (input valid, mode, stack_pointer, program_counter, output ready);
endinterface

interface cts_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cts_pkg::STATUS_W-1:0]      status;
    logic [cts_pkg::IDX_W-1:0]         task_index;
    logic [cts_pkg::WORD_W-1:0]        resume_sp;
    logic [cts_pkg::WORD_W-1:0]        resume_pc;

    modport source (output valid, status, task_index, resume_sp, resume_pc, input ready);
    modport sink   (input valid, status, task_index, resume_sp, resume_pc, output ready);
endinterface

// ===== hw/rtl/cts_ctrl.sv =====
// Sequencing controller for the task scheduler: accept, execute, write back.
// Depends on cts_pkg for the command struct.
module cts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    output logic              o_in_ready,
    output cts_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WB
    } t_fsm;

    t_fsm r_state;
    t_fsm n_state;
    logic accept;

    always_comb begin
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_WB:    o_in_ready = i_out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign accept        = i_in_valid & o_in_ready;
    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_WB) & i_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_WB;
            S_WB: begin
                // A new transfer can be taken in the same cycle the result is loaded.
                if (i_out_free) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/cts_dp.sv =====
// Scheduler datapath: task table, context memory, pickers and result register.
// Depends on cts_pkg; driven by commands from cts_ctrl.
module cts_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cts_pkg::t_ctl_cmd               i_cmd,
    input  logic [cts_pkg::MODE_W-1:0]      i_mode,
    input  logic [cts_pkg::WORD_W-1:0]      i_sp,
    input  logic [cts_pkg::WORD_W-1:0]      i_pc,
    input  logic                            i_out_ready,
    output logic                            o_out_free,
    output logic                            o_out_valid,
    output logic [cts_pkg::STATUS_W-1:0]    o_status,
    output logic [cts_pkg::IDX_W-1:0]       o_task_index,
    output logic [cts_pkg::WORD_W-1:0]      o_resume_sp,
    output logic [cts_pkg::WORD_W-1:0]      o_resume_pc
);

    localparam int N  = cts_pkg::MAX_TASKS;
    localparam int SW = cts_pkg::SLOT_W;
    localparam int CW = cts_pkg::CNT_W;
    localparam int WW = cts_pkg::WORD_W;
    localparam int IW = cts_pkg::IDX_W;

    // Captured event.
    cts_pkg::t_mode  r_mode;
    logic [WW-1:0]   r_sp;
    logic [WW-1:0]   r_pc;

    // Task table and scheduler state.
    cts_pkg::t_slot_state r_slot_state [N];
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   r_cur;
    logic            r_cur_valid;

    // Context memory.
    logic [WW-1:0]   mem_sp [N];
    logic [WW-1:0]   mem_pc [N];
    logic [WW-1:0]   r_rd_sp;
    logic [WW-1:0]   r_rd_pc;

    // Result of the execute step, registered together with the read data.
    cts_pkg::t_status r_res_status;
    logic [SW-1:0]   r_res_slot;
    logic            r_res_use;

    // Result register.
    logic            r_out_valid;
    cts_pkg::t_status r_out_status;
    logic [IW-1:0]   r_out_idx;
    logic [WW-1:0]   r_out_sp;
    logic [WW-1:0]   r_out_pc;

    logic [N-1:0]    ready_mask;
    logic [N-1:0]    above_mask;
    logic            low_hit;
    logic [SW-1:0]   low_slot;
    logic            above_hit;
    logic [SW-1:0]   above_slot;
    logic            wrap_hit;
    logic [SW-1:0]   wrap_slot;
    logic            yield_hit;
    logic [SW-1:0]   yield_slot;
    logic            table_full;
    logic [SW-1:0]   new_slot;

    logic            wr_en;
    logic [SW-1:0]   wr_addr;
    logic [SW-1:0]   rd_addr;
    logic            set_en;
    logic [SW-1:0]   set_slot;
    cts_pkg::t_slot_state set_val;
    logic            run_en;
    logic [SW-1:0]   run_slot;
    logic            cnt_inc;
    logic            clr_cur;
    cts_pkg::t_status res_status;
    logic [SW-1:0]   res_slot;
    logic            res_use;
    logic [IW+SW-1:0] idx_wide;

    assign table_full = (r_count >= CW'(N));
    assign new_slot   = r_count[SW-1:0];

    always_comb begin
        for (int i = 0; i < N; i++) begin
            ready_mask[i] = (r_slot_state[i] == cts_pkg::ST_READY);
            above_mask[i] = (SW'(i) > r_cur);
        end
    end

    // Priority encoders: lowest ready slot overall, above the current slot,
    // and overall excluding the current slot (the wrapped part of the search).
    always_comb begin
        low_hit    = 1'b0;
        low_slot   = '0;
        above_hit  = 1'b0;
        above_slot = '0;
        wrap_hit   = 1'b0;
        wrap_slot  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (ready_mask[i]) begin
                low_hit  = 1'b1;
                low_slot = SW'(i);
            end
            if (ready_mask[i] && above_mask[i]) begin
                above_hit  = 1'b1;
                above_slot = SW'(i);
            end
            if (ready_mask[i] && (SW'(i) != r_cur)) begin
                wrap_hit  = 1'b1;
                wrap_slot = SW'(i);
            end
        end
    end

    assign yield_hit  = above_hit | wrap_hit;
    assign yield_slot = above_hit ? above_slot : wrap_slot;

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = new_slot;
        rd_addr    = low_slot;
        set_en     = 1'b0;
        set_slot   = r_cur;
        set_val    = cts_pkg::ST_READY;
        run_en     = 1'b0;
        run_slot   = low_slot;
        cnt_inc    = 1'b0;
        clr_cur    = 1'b0;
        res_status = cts_pkg::RES_ERROR;
        res_slot   = '0;
        res_use    = 1'b0;
        unique case (r_mode)
            cts_pkg::MODE_CREATE: begin
                if (!table_full) begin
                    wr_en      = 1'b1;
                    wr_addr    = new_slot;
                    set_en     = 1'b1;
                    set_slot   = new_slot;
                    set_val    = cts_pkg::ST_READY;
                    cnt_inc    = 1'b1;
                    res_status = cts_pkg::RES_CONTINUE;
                    res_slot   = new_slot;
                end
            end
            cts_pkg::MODE_YIELD: begin
                if (r_cur_valid) begin
                    if (yield_hit) begin
                        wr_en      = 1'b1;
                        wr_addr    = r_cur;
                        set_en     = 1'b1;
                        set_slot   = r_cur;
                        set_val    = cts_pkg::ST_READY;
                        run_en     = 1'b1;
                        run_slot   = yield_slot;
                        rd_addr    = yield_slot;
                        res_status = cts_pkg::RES_SWITCH;
                        res_slot   = yield_slot;
                        res_use    = 1'b1;
                    end else begin
                        res_status = cts_pkg::RES_CONTINUE;
                        res_slot   = r_cur;
                    end
                end
            end
            default: begin
                // Exit retires the current task first; it is running, so the
                // pick below is not affected by that change.
                if (r_mode == cts_pkg::MODE_EXIT && r_cur_valid) begin
                    set_en   = 1'b1;
                    set_slot = r_cur;
                    set_val  = cts_pkg::ST_FINISHED;
                end
                if (low_hit) begin
                    run_en     = 1'b1;
                    run_slot   = low_slot;
                    rd_addr    = low_slot;
                    res_status = cts_pkg::RES_SWITCH;
                    res_slot   = low_slot;
                    res_use    = 1'b1;
                end else begin
                    clr_cur    = 1'b1;
                    res_status = cts_pkg::RES_NONE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= cts_pkg::t_mode'(i_mode);
            r_sp   <= i_sp;
            r_pc   <= i_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_slot_state[i] <= cts_pkg::ST_INVALID;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            if (set_en) r_slot_state[set_slot] <= set_val;
            if (run_en) begin
                r_slot_state[run_slot] <= cts_pkg::ST_RUNNING;
                r_cur                  <= run_slot;
                r_cur_valid            <= 1'b1;
            end
            if (clr_cur) r_cur_valid <= 1'b0;
            if (cnt_inc) r_count <= r_count + CW'(1);
        end
    end

    // A switch on yield writes the current slot and reads another one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (wr_en) begin
                mem_sp[wr_addr] <= r_sp;
                mem_pc[wr_addr] <= r_pc;
            end
            r_rd_sp      <= mem_sp[rd_addr];
            r_rd_pc      <= mem_pc[rd_addr];
            r_res_status <= res_status;
            r_res_slot   <= res_slot;
            r_res_use    <= res_use;
        end
    end

    assign idx_wide = {{IW{1'b0}}, r_res_slot};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= idx_wide[IW-1:0];
            r_out_sp     <= r_res_use ? r_rd_sp : '0;
            r_out_pc     <= r_res_use ? r_rd_pc : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_task_index = r_out_idx;
    assign o_resume_sp  = r_out_sp;
    assign o_resume_pc  = r_out_pc;

endmodule

// ===== hw/rtl/cooperative_task_scheduler_core.sv =====
// Cooperative round-robin task scheduler. Each event on the request channel
// (create, yield, exit, start) produces exactly one result on the response
// channel. An event first searches the task table (a yield rotates from the
// current task, exit and start take the lowest ready slot) and accesses the
// context memory, then loads the result register. A new event is accepted
// in the same cycle a result is loaded while the response side keeps up. A
// result waiting in the output register does not block the next event from
// being accepted and executed.
// Depends on cts_pkg, cts_ifs, cts_ctrl and cts_dp.
module cooperative_task_scheduler_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cts_req_if.sink   i_req,
    cts_rsp_if.source o_rsp
);

    cts_pkg::t_ctl_cmd cmd;
    logic              out_free;

    cts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_out_free (out_free),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    cts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_req.mode),
        .i_sp         (i_req.stack_pointer),
        .i_pc         (i_req.program_counter),
        .i_out_ready  (o_rsp.ready),
        .o_out_free   (out_free),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_task_index (o_rsp.task_index),
        .o_resume_sp  (o_rsp.resume_sp),
        .o_resume_pc  (o_rsp.resume_pc)
    );

endmodule

// ===== tb/tb_cooperative_task_scheduler_core.sv =====
// Self-checking testbench for cooperative_task_scheduler_core. It sends task events over
// the request channel and checks every response against a task table kept in the bench.
// Depends on cts_pkg, the cts_req_if / cts_rsp_if interfaces and the scheduler RTL.
`timescale 1ns / 100ps

module tb_cooperative_task_scheduler_core;

    typedef logic [cts_pkg::WORD_W-1:0] t_word;

    typedef struct {
        cts_pkg::t_mode mode;
        t_word          sp;
        t_word          pc;
        bit             drain;    // hold this event back until every response has arrived
    } t_sched_event;

    typedef struct {
        cts_pkg::t_status              status;
        logic [cts_pkg::IDX_W-1:0]     task_index;
        t_word                         resume_sp;
        t_word                         resume_pc;
    } t_dispatch;

    localparam int HOLD_LEN    = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 16;

    logic i_clk;
    logic i_rst_n;

    cts_req_if req_if ();
    cts_rsp_if rsp_if ();

    cooperative_task_scheduler_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Task table as the bench expects it to be.
    cts_pkg::t_slot_state slot_st  [cts_pkg::MAX_TASKS];
    t_word                saved_sp [cts_pkg::MAX_TASKS];
    t_word                saved_pc [cts_pkg::MAX_TASKS];
    int                   n_created;
    int unsigned          cur_slot;
    bit                   cur_valid;

    t_sched_event event_q [$];
    t_dispatch    dispatch_q [$];

    int n_total;
    int n_accepted;
    int n_checked;
    int mismatches;
    int idle_cycles;
    int hold_cnt;
    bit hold_done;
    bit timed_out;

    t_sched_event next_ev;
    t_dispatch    want;
    int           src_idle;
    int           snk_idle;
    int           phase;
    int           snk_phase;
    int           accepted_now;
    bit           req_xfer;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_dispatch schedule_event(cts_pkg::t_mode m, t_word sp, t_word pc);
        t_dispatch   r;
        int unsigned s;
        bit          hit;
        r.status     = cts_pkg::RES_ERROR;
        r.task_index = '0;
        r.resume_sp  = '0;
        r.resume_pc  = '0;
        hit          = 1'b0;
        unique case (m)
            cts_pkg::MODE_CREATE: begin
                if (n_created < cts_pkg::MAX_TASKS) begin
                    slot_st[n_created]  = cts_pkg::ST_READY;
                    saved_sp[n_created] = sp;
                    saved_pc[n_created] = pc;
                    r.status            = cts_pkg::RES_CONTINUE;
                    r.task_index        = n_created[cts_pkg::IDX_W-1:0];
                    n_created++;
                end
            end
            cts_pkg::MODE_YIELD: begin
                if (cur_valid) begin
                    r.status     = cts_pkg::RES_CONTINUE;
                    r.task_index = cur_slot[cts_pkg::IDX_W-1:0];
                    // Round-robin search that starts after the current slot and wraps.
                    for (int k = 1; k < cts_pkg::MAX_TASKS && !hit; k++) begin
                        s = (cur_slot + k) % cts_pkg::MAX_TASKS;
                        if (slot_st[s] == cts_pkg::ST_READY) begin
                            saved_sp[cur_slot] = sp;
                            saved_pc[cur_slot] = pc;
                            slot_st[cur_slot]  = cts_pkg::ST_READY;
                            slot_st[s]         = cts_pkg::ST_RUNNING;
                            cur_slot           = s;
                            r.status           = cts_pkg::RES_SWITCH;
                            r.task_index       = s[cts_pkg::IDX_W-1:0];
                            r.resume_sp        = saved_sp[s];
                            r.resume_pc        = saved_pc[s];
                            hit                = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // Exit retires the current task; start leaves a running task as it is.
                if (m == cts_pkg::MODE_EXIT && cur_valid)
                    slot_st[cur_slot] = cts_pkg::ST_FINISHED;
                r.status  = cts_pkg::RES_NONE;
                cur_valid = 1'b0;
                for (int k = 0; k < cts_pkg::MAX_TASKS && !hit; k++) begin
                    if (slot_st[k] == cts_pkg::ST_READY) begin
                        slot_st[k]   = cts_pkg::ST_RUNNING;
                        cur_slot     = k;
                        cur_valid    = 1'b1;
                        r.status     = cts_pkg::RES_SWITCH;
                        r.task_index = k[cts_pkg::IDX_W-1:0];
                        r.resume_sp  = saved_sp[k];
                        r.resume_pc  = saved_pc[k];
                        hit          = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_event(cts_pkg::t_mode m, t_word sp, t_word pc, bit drain);
        t_sched_event ev;
        ev.mode  = m;
        ev.sp    = sp;
        ev.pc    = pc;
        ev.drain = drain;
        event_q.push_back(ev);
    endtask

    task automatic report_mismatch(string what, t_word exp_v, t_word got_v);
        $display("[%0t] mismatch at response %0d, %s: expected %h, got %h",
                 $realtime, n_checked, what, exp_v, got_v);
        mismatches++;
    endtask

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Random events; weights are create, yield, exit, in percent, start takes the rest.
    task automatic add_random(int count, int w_create, int w_yield, int w_exit);
        int             pick;
        cts_pkg::t_mode m;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < w_create)
                m = cts_pkg::MODE_CREATE;
            else if (pick < w_create + w_yield)
                m = cts_pkg::MODE_YIELD;
            else if (pick < w_create + w_yield + w_exit)
                m = cts_pkg::MODE_EXIT;
            else
                m = cts_pkg::MODE_START;
            add_event(m, rand_word(), rand_word(), 1'b0);
        end
    endtask

    // Request driver: the prediction is made when the transfer takes place.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid           <= 1'b0;
            req_if.mode            <= cts_pkg::MODE_CREATE;
            req_if.stack_pointer   <= '0;
            req_if.program_counter <= '0;
            n_accepted             <= 0;
        end else begin
            req_xfer     = req_if.valid && req_if.ready;
            accepted_now = n_accepted;
            if (req_xfer) begin
                dispatch_q.push_back(schedule_event(cts_pkg::t_mode'(req_if.mode),
                                                    req_if.stack_pointer,
                                                    req_if.program_counter));
                accepted_now = n_accepted + 1;
                n_accepted <= accepted_now;
            end
            phase = (n_total > 0) ? (accepted_now * 3) / n_total : 0;
            case (phase)
                0:       src_idle = 30;
                1:       src_idle = 51;
                default: src_idle = 0;
            endcase
            if (hold_cnt > 0)
                src_idle = 0;
            if (!req_if.valid || req_if.ready) begin
                if (event_q.size() > 0 && $urandom_range(99) >= src_idle &&
                    !(event_q[0].drain && n_checked != accepted_now)) begin
                    next_ev                 = event_q.pop_front();
                    req_if.valid           <= 1'b1;
                    req_if.mode            <= next_ev.mode;
                    req_if.stack_pointer   <= next_ev.sp;
                    req_if.program_counter <= next_ev.pc;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and ready generator, with one long hold-off mid-run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            n_checked    <= 0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (dispatch_q.size() == 0) begin
                    report_mismatch("unexpected response", '0, '0);
                end else begin
                    want = dispatch_q.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", t_word'(want.status),
                                        t_word'(rsp_if.status));
                    if (rsp_if.task_index !== want.task_index)
                        report_mismatch("task_index", t_word'(want.task_index),
                                        t_word'(rsp_if.task_index));
                    if (rsp_if.resume_sp !== want.resume_sp)
                        report_mismatch("resume_sp", want.resume_sp, rsp_if.resume_sp);
                    if (rsp_if.resume_pc !== want.resume_pc)
                        report_mismatch("resume_pc", want.resume_pc, rsp_if.resume_pc);
                end
                n_checked <= n_checked + 1;
            end
            snk_phase = (n_total > 0) ? (n_accepted * 3) / n_total : 0;
            case (snk_phase)
                0:       snk_idle = 51;
                1:       snk_idle = 30;
                default: snk_idle = 0;
            endcase
            if (hold_cnt > 0) begin
                hold_cnt     <= hold_cnt - 1;
                rsp_if.ready <= 1'b0;
            end else if (!hold_done && n_total > 0 && n_accepted >= n_total / 2) begin
                hold_cnt     <= HOLD_LEN;
                hold_done    <= 1'b1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // Counts cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n                = 1'b0;
        n_total                = 0;
        mismatches             = 0;
        timed_out              = 1'b0;
        n_created              = 0;
        cur_slot               = 0;
        cur_valid              = 1'b0;
        for (int k = 0; k < cts_pkg::MAX_TASKS; k++) begin
            slot_st[k]  = cts_pkg::ST_INVALID;
            saved_sp[k] = '0;
            saved_pc[k] = '0;
        end

        // Empty table, then no current task, then context save and restore at the extremes.
        add_event(cts_pkg::MODE_START,  '0, '0, 1'b0);
        add_event(cts_pkg::MODE_YIELD,  '1, '1, 1'b0);
        add_event(cts_pkg::MODE_EXIT,   '0, '0, 1'b0);
        add_event(cts_pkg::MODE_CREATE, '0, '0, 1'b0);
        add_event(cts_pkg::MODE_CREATE, '1, '1, 1'b0);
        add_event(cts_pkg::MODE_YIELD,  '0, '1, 1'b0);
        add_event(cts_pkg::MODE_START,  '1, '0, 1'b0);
        add_event(cts_pkg::MODE_YIELD,  '1, '0, 1'b0);
        add_event(cts_pkg::MODE_YIELD,  '0, '1, 1'b0);
        add_event(cts_pkg::MODE_CREATE, {32{2'b01}}, {32{2'b10}}, 1'b0);
        add_event(cts_pkg::MODE_YIELD,  {32{2'b10}}, {32{2'b01}}, 1'b0);
        add_event(cts_pkg::MODE_YIELD,  rand_word(), rand_word(), 1'b0);
        // The search from the highest busy slot has to wrap back to slot zero.
        add_event(cts_pkg::MODE_YIELD,  rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_EXIT,   rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_EXIT,   rand_word(), rand_word(), 1'b0);
        // Only the current task is left, so a yield keeps it running.
        add_event(cts_pkg::MODE_YIELD,  rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_CREATE, rand_word(), rand_word(), 1'b0);
        // Start while a task runs: the running task is left in place, the new one is picked.
        add_event(cts_pkg::MODE_START,  rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_EXIT,   rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_YIELD,  rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_CREATE, rand_word(), rand_word(), 1'b0);
        add_event(cts_pkg::MODE_START,  rand_word(), rand_word(), 1'b0);

        // Mostly yields among live tasks; slots are never freed, so exits stay rare.
        add_random(200, 10, 86, 2);
        // Fill the table for certain and push past it, after a full drain.
        add_event(cts_pkg::MODE_CREATE, rand_word(), rand_word(), 1'b1);
        for (int i = 0; i < cts_pkg::MAX_TASKS - 3; i++)
            add_event(cts_pkg::MODE_CREATE, rand_word(), rand_word(), 1'b0);
        add_random(200, 8, 80, 8);
        n_total = event_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                wait (n_accepted == n_total);
                wait (n_checked == n_accepted);
                repeat (SETTLE_CYC) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && dispatch_q.size() != 0)
            report_mismatch("responses never arrived", t_word'(dispatch_q.size()), '0);
        if (!timed_out && mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== cooperative_task_scheduler_core.f =====
hw/rtl/cts_pkg.sv
hw/rtl/cts_ifs.sv
hw/rtl/cts_ctrl.sv
hw/rtl/cts_dp.sv
hw/rtl/cooperative_task_scheduler_core.sv
tb/tb_cooperative_task_scheduler_core.sv
